### src/v3alu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3alu_pkg
// shared types and codes for the scalar / three-vector fixed-point alu
// ----------------------------------------------------------------------------
package v3alu_pkg;

    localparam int QW      = 32;
    localparam int LANES   = 3;
    localparam int DIV_W   = 48;                 // dividend is left << 16
    localparam int DIV_STG = 16;                 // pipelined divider stages
    localparam int DIV_BPS = DIV_W / DIV_STG;    // quotient bits per stage

    typedef logic signed [QW-1:0] q_t;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ERR_OK   = 2'd0,
        ERR_TYPE = 2'd1,
        ERR_DIV0 = 2'd2
    } err_t;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        KIND_ADD = 3'd0,
        KIND_SUB = 3'd1,
        KIND_MUL = 3'd2,
        KIND_DIV = 3'd3,
        KIND_ERR = 3'd4
    } kind_t;

    typedef struct packed {
        logic [QW-1:0] num;
        logic [QW-1:0] x;
        logic [QW-1:0] y;
        logic [QW-1:0] z;
    } opnd_t;

    typedef struct packed {
        logic [1:0]    command;
        logic          left_is_vec;
        opnd_t         left;
        logic          right_is_vec;
        opnd_t         right;
    } req_t;

    typedef struct packed {
        kind_t                    kind;
        err_t                     err;
        logic                     is_vec;
        logic [LANES-1:0][QW-1:0] a;
        logic [LANES-1:0][QW-1:0] b;
    } op_t;

    typedef struct packed {
        logic          is_vec;
        logic [QW-1:0] num;
        logic [QW-1:0] x;
        logic [QW-1:0] y;
        logic [QW-1:0] z;
        logic [1:0]    error_code;
    } rsp_t;

    function automatic logic [QW-1:0] sat_wide(input logic signed [QW+17:0] v);
        logic signed [QW+17:0] hi;
        logic signed [QW+17:0] lo;
        begin
            hi = (QW+18)'(signed'({1'b0, {(QW-1){1'b1}}}));
            lo = -hi - (QW+18)'(1);
            if (v > hi)
                sat_wide = {1'b0, {(QW-1){1'b1}}};
            else if (v < lo)
                sat_wide = {1'b1, {(QW-1){1'b0}}};
            else
                sat_wide = v[QW-1:0];
        end
    endfunction

endpackage

### src/v3alu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3alu_req_if / v3alu_rsp_if
// valid / ready channels for requests and results
// ----------------------------------------------------------------------------
interface v3alu_req_if;
    import v3alu_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface v3alu_rsp_if;
    import v3alu_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/v3alu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3alu_front
// type check, divide-by-zero check and operand routing, one register stage
// ----------------------------------------------------------------------------
module v3alu_front
    import v3alu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output op_t  out_op
);

    logic valid_reg;
    op_t  op_reg;
    op_t  op_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_op    = op_reg;

    always_comb
    begin
        logic lv;
        logic rv;
        lv = in_data.left_is_vec;
        rv = in_data.right_is_vec;
        op_next.kind   = KIND_ERR;
        op_next.err    = ERR_OK;
        op_next.is_vec = 1'b0;
        op_next.a = {in_data.left.z, in_data.left.y, in_data.left.x};
        op_next.b = {in_data.right.z, in_data.right.y, in_data.right.x};
        unique case (cmd_t'(in_data.command))
            CMD_ADD, CMD_SUB:
            begin
                if (lv == rv)
                begin
                    op_next.kind = (cmd_t'(in_data.command) == CMD_ADD) ? KIND_ADD : KIND_SUB;
                    op_next.is_vec = lv;
                    if (!lv)
                    begin
                        op_next.a[0] = in_data.left.num;
                        op_next.b[0] = in_data.right.num;
                    end
                end
                else
                    op_next.err = ERR_TYPE;
            end
            CMD_MUL:
            begin
                op_next.kind   = KIND_MUL;
                op_next.is_vec = lv || rv;
                if (!lv && !rv)
                begin
                    op_next.a[0] = in_data.left.num;
                    op_next.b[0] = in_data.right.num;
                end
                else if (lv && !rv)
                    op_next.b = {3{in_data.right.num}};
                else if (!lv && rv)
                    op_next.a = {3{in_data.left.num}};
            end
            CMD_DIV:
            begin
                if (rv)
                    op_next.err = ERR_TYPE;
                else if (in_data.right.num == '0)
                    op_next.err = ERR_DIV0;
                else
                begin
                    op_next.kind   = KIND_DIV;
                    op_next.is_vec = lv;
                    op_next.b      = {3{in_data.right.num}};
                    if (!lv)
                        op_next.a[0] = in_data.left.num;
                end
            end
            default: op_next.err = ERR_TYPE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            op_reg <= op_next;
    end

    err_chk: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && op_reg.err != ERR_OK |-> op_reg.kind == KIND_ERR && !op_reg.is_vec)
        else $error("error op carries a kind or vector flag");

endmodule

### src/v3alu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3alu_back
// three lanes (x, y, z), each with add/sub, multiply and a pipelined restoring divider
// ----------------------------------------------------------------------------
module v3alu_back
    import v3alu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  op_t  in_op,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out_rsp
);

    // pipeline: s0 entry register holding sums / products, DIV_STG divider stages,
    // then output register. the whole line advances together when the output is free
    localparam int DEPTH = DIV_STG + 1;

    logic adv;
    logic out_valid_reg;
    rsp_t out_reg;

    // per-stage control and operand state
    logic [DEPTH-1:0]                     v_reg;
    kind_t                                kind_reg   [DEPTH];
    err_t                                 err_reg    [DEPTH];
    logic                                 vec_reg    [DEPTH];
    logic [LANES-1:0][QW-1:0]             fast_reg   [DEPTH];  // add/sub/mul results
    logic [LANES-1:0][DIV_W-1:0]          rem_reg    [DEPTH];
    logic [LANES-1:0][DIV_W-1:0]          quo_reg    [DEPTH];  // dividend shifts out, q in
    logic [LANES-1:0][QW-1:0]             dvs_reg    [DEPTH];  // |divisor|
    logic [LANES-1:0]                     neg_reg    [DEPTH];

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // stage 0 compute
    logic [LANES-1:0][QW-1:0]    fast0;
    logic [LANES-1:0][DIV_W-1:0] dvd0;
    logic [LANES-1:0][QW-1:0]    dvs0;
    logic [LANES-1:0]            neg0;

    always_comb
    begin
        logic signed [QW:0]     s;
        logic signed [2*QW-1:0] p;
        logic signed [2*QW-1:0] ps;
        logic signed [DIV_W-1:0] dd;
        for (int i = 0; i < LANES; i++)
        begin
            s = '0;
            if (in_op.kind == KIND_SUB)
                s = (QW+1)'(signed'(in_op.a[i])) - (QW+1)'(signed'(in_op.b[i]));
            else
                s = (QW+1)'(signed'(in_op.a[i])) + (QW+1)'(signed'(in_op.b[i]));
            p  = (2*QW)'(signed'(in_op.a[i])) * (2*QW)'(signed'(in_op.b[i]));
            ps = p >>> 16;
            if (in_op.kind == KIND_MUL)
                fast0[i] = sat_wide((QW+18)'(ps));
            else
                fast0[i] = sat_wide((QW+18)'(s));
            dd = (DIV_W)'(signed'(in_op.a[i])) <<< 16;
            dvd0[i] = dd[DIV_W-1] ? -dd : dd;
            dvs0[i] = in_op.b[i][QW-1] ? -in_op.b[i] : in_op.b[i];
            neg0[i] = in_op.a[i][QW-1] ^ in_op.b[i][QW-1];
        end
    end

    // one divider step group
    function automatic void div_step(input logic [DIV_W-1:0] r_in,
                                     input logic [DIV_W-1:0] q_in,
                                     input logic [QW-1:0] d,
                                     output logic [DIV_W-1:0] r_out,
                                     output logic [DIV_W-1:0] q_out);
        logic [DIV_W:0] t;
        begin
            r_out = r_in;
            q_out = q_in;
            for (int k = 0; k < DIV_BPS; k++)
            begin
                t = {r_out, q_out[DIV_W-1]};
                q_out = {q_out[DIV_W-2:0], 1'b0};
                if (t >= (DIV_W+1)'(d))
                begin
                    t = t - (DIV_W+1)'(d);
                    q_out[0] = 1'b1;
                end
                r_out = t[DIV_W-1:0];
            end
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[DEPTH-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        logic [DIV_W-1:0] rem_nx;
        logic [DIV_W-1:0] quo_nx;
        if (adv)
        begin
            kind_reg[0] <= in_op.kind;
            err_reg[0]  <= in_op.err;
            vec_reg[0]  <= in_op.is_vec;
            fast_reg[0] <= fast0;
            neg_reg[0]  <= neg0;
            dvs_reg[0]  <= dvs0;
            for (int i = 0; i < LANES; i++)
            begin
                rem_reg[0][i] <= '0;
                quo_reg[0][i] <= dvd0[i];
            end
            for (int s = 1; s < DEPTH; s++)
            begin
                kind_reg[s] <= kind_reg[s-1];
                err_reg[s]  <= err_reg[s-1];
                vec_reg[s]  <= vec_reg[s-1];
                fast_reg[s] <= fast_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                dvs_reg[s]  <= dvs_reg[s-1];
                for (int i = 0; i < LANES; i++)
                begin
                    div_step(rem_reg[s-1][i], quo_reg[s-1][i], dvs_reg[s-1][i],
                             rem_nx, quo_nx);
                    rem_reg[s][i] <= rem_nx;
                    quo_reg[s][i] <= quo_nx;
                end
            end
        end
    end

    // final assembly
    rsp_t rsp_next;
    always_comb
    begin
        logic [LANES-1:0][QW-1:0] val;
        logic signed [QW+17:0]    qs;
        kind_t k;
        k = kind_reg[DEPTH-1];
        for (int i = 0; i < LANES; i++)
        begin
            qs = (QW+18)'(signed'({1'b0, quo_reg[DEPTH-1][i]}));
            if (neg_reg[DEPTH-1][i])
                qs = -qs;
            if (k == KIND_DIV)
                val[i] = sat_wide(qs);
            else
                val[i] = fast_reg[DEPTH-1][i];
        end
        rsp_next = '0;
        rsp_next.error_code = err_reg[DEPTH-1];
        if (k != KIND_ERR)
        begin
            rsp_next.is_vec = vec_reg[DEPTH-1];
            if (vec_reg[DEPTH-1])
            begin
                rsp_next.x = val[0];
                rsp_next.y = val[1];
                rsp_next.z = val[2];
            end
            else
                rsp_next.num = val[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= v_reg[DEPTH-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= rsp_next;
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_reg;

    hold_chk: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_reg))
        else $error("result changed while stalled");
    zero_chk: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.error_code != ERR_OK |->
        !out_reg.is_vec && out_reg.num == '0 && out_reg.x == '0)
        else $error("error result not cleared");

endmodule

### src/vec3_scalar_alu_top.sv
`timescale 1ns / 1ps
// path: the front register loads a request at acceptance, then it passes the
// back entry stage, 16 divider stages and the output register to result valid
// throughput: one transaction per cycle unless stalled, divider fully pipelined
// the divider pipeline (16 stages of 3 quotient bits per lane) sets the latency
// reset: rst_n asynchronous active low clears every valid flag; no memories
// ----------------------------------------------------------------------------
// vec3_scalar_alu_top
// scalar / three-vector q16.16 alu with add, sub, mul, div and error codes
// ----------------------------------------------------------------------------
module vec3_scalar_alu_top
    import v3alu_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    v3alu_req_if.sink   req,
    v3alu_rsp_if.source rsp
);

    // front classifies each transaction, back runs the arithmetic lanes
    logic fb_valid;
    logic fb_ready;
    op_t  fb_op;

    v3alu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_data   (req.data),
        .out_valid (fb_valid),
        .out_ready (fb_ready),
        .out_op    (fb_op)
    );

    // back stalls as one line when the output register is held
    v3alu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fb_valid),
        .in_ready  (fb_ready),
        .in_op     (fb_op),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_rsp   (rsp.data)
    );

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the q16.16 scalar / three-vector alu: a directed
// table with hand-typed results where obvious, then random requests under
// several handshake idling mixes, every result checked against a predictor
// ----------------------------------------------------------------------------
module tb;
    import v3alu_pkg::*;

    localparam int LATENCY   = 19;
    localparam int N_RANDOM  = 500;
    localparam int MAX_CYCLE = 400000;

    // one directed row; chk marks a result typed in by hand
    typedef struct {
        req_t req;
        logic chk;
        rsp_t rsp;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    v3alu_req_if req_ch ();
    v3alu_rsp_if rsp_ch ();

    vec3_scalar_alu_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always #5 clk = ~clk;

    rsp_t        pending_results[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        hold_off = 1'b0;
    row_t        directed_rows[$];

    // ------------------------------------------------------------------
    // predictor: saturating q16.16 arithmetic in 64-bit signed math
    // ------------------------------------------------------------------
    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] q_mul(input logic [31:0] a, input logic [31:0] b);
        longint p;
        begin
            p = longint'($signed(a)) * longint'($signed(b));
            // arithmetic shift rounds toward minus infinity
            return clamp32(p >>> 16);
        end
    endfunction

    function automatic logic [31:0] q_div(input logic [31:0] a, input logic [31:0] b);
        longint n;
        begin
            n = longint'($signed(a)) * 64'sd65536;
            // sv division truncates toward zero
            return clamp32(n / longint'($signed(b)));
        end
    endfunction

    function automatic logic [31:0] q_addsub(input logic [31:0] a, input logic [31:0] b,
                                             input logic sub);
        longint s;
        begin
            s = sub ? longint'($signed(a)) - longint'($signed(b))
                    : longint'($signed(a)) + longint'($signed(b));
            return clamp32(s);
        end
    endfunction

    function automatic rsp_t alu_predict(input req_t r);
        rsp_t o;
        logic [31:0] la[3];
        logic [31:0] ra[3];
        logic [31:0] res[3];
        begin
            o = '0;
            la = '{r.left.x, r.left.y, r.left.z};
            ra = '{r.right.x, r.right.y, r.right.z};
            res = '{32'd0, 32'd0, 32'd0};
            o.error_code = ERR_OK;
            case (cmd_t'(r.command))
                CMD_ADD, CMD_SUB:
                begin
                    if (!r.left_is_vec && !r.right_is_vec)
                        o.num = q_addsub(r.left.num, r.right.num, r.command == CMD_SUB);
                    else if (r.left_is_vec && r.right_is_vec)
                    begin
                        o.is_vec = 1'b1;
                        for (int i = 0; i < 3; i++)
                            res[i] = q_addsub(la[i], ra[i], r.command == CMD_SUB);
                    end
                    else
                        o.error_code = ERR_TYPE;
                end
                CMD_MUL:
                begin
                    if (!r.left_is_vec && !r.right_is_vec)
                        o.num = q_mul(r.left.num, r.right.num);
                    else
                    begin
                        o.is_vec = 1'b1;
                        for (int i = 0; i < 3; i++)
                            if (r.left_is_vec && r.right_is_vec)
                                res[i] = q_mul(la[i], ra[i]);
                            else if (r.left_is_vec)
                                res[i] = q_mul(la[i], r.right.num);
                            else
                                res[i] = q_mul(ra[i], r.left.num);
                    end
                end
                default:
                begin
                    // type check before the zero divisor check
                    if (r.right_is_vec)
                        o.error_code = ERR_TYPE;
                    else if (r.right.num == 32'd0)
                        o.error_code = ERR_DIV0;
                    else if (!r.left_is_vec)
                        o.num = q_div(r.left.num, r.right.num);
                    else
                    begin
                        o.is_vec = 1'b1;
                        for (int i = 0; i < 3; i++)
                            res[i] = q_div(la[i], r.right.num);
                    end
                end
            endcase
            if (o.error_code != ERR_OK)
            begin
                o.is_vec = 1'b0;
                o.num = '0;
                res = '{32'd0, 32'd0, 32'd0};
            end
            o.x = res[0];
            o.y = res[1];
            o.z = res[2];
            return o;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [31:0] rand_q();
        // bias toward small values, extremes and fully random bit patterns
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 20'hfffff)) - 20'sh80000);
            2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            3: return 32'($urandom_range(0, 2000)) << 16;
            4: return -(32'($urandom_range(0, 2000)) << 16);
            default: return $urandom_range(0, 3) == 0 ? 32'd0 : $urandom;
        endcase
    endfunction

    function automatic opnd_t rand_opnd();
        opnd_t o;
        begin
            o.num = rand_q();
            o.x = rand_q();
            o.y = rand_q();
            o.z = rand_q();
            return o;
        end
    endfunction

    function automatic req_t rand_req();
        req_t r;
        begin
            r.command = 2'($urandom_range(0, 3));
            r.left_is_vec = 1'($urandom_range(0, 1));
            r.right_is_vec = 1'($urandom_range(0, 1));
            r.left = rand_opnd();
            r.right = rand_opnd();
            // most divides are well typed with a nonzero divisor
            if (r.command == CMD_DIV && $urandom_range(0, 3) != 0)
            begin
                r.right_is_vec = 1'b0;
                if (r.right.num == 32'd0)
                    r.right.num = 32'h0001_0000;
            end
            return r;
        end
    endfunction

    function automatic req_t mk_req(input cmd_t c, input logic lv, input logic [31:0] ln,
                                    input logic [31:0] lx, input logic rv,
                                    input logic [31:0] rn, input logic [31:0] rx);
        req_t r;
        begin
            r.command = c;
            r.left_is_vec = lv;
            r.left = '{num: ln, x: lx, y: ~lx, z: lx ^ 32'h5555_5555};
            r.right_is_vec = rv;
            r.right = '{num: rn, x: rx, y: ~rx, z: rx ^ 32'haaaa_aaaa};
            return r;
        end
    endfunction

    function automatic rsp_t err_rsp(input err_t e);
        rsp_t o;
        begin
            o = '0;
            o.error_code = e;
            return o;
        end
    endfunction

    function automatic rsp_t num_rsp(input logic [31:0] n);
        rsp_t o;
        begin
            o = '0;
            o.num = n;
            o.error_code = ERR_OK;
            return o;
        end
    endfunction

    task automatic add_row(input req_t r, input logic chk, input rsp_t o);
        row_t w;
        begin
            w.req = r;
            w.chk = chk;
            w.rsp = o;
            directed_rows.push_back(w);
        end
    endtask

    // drive one transaction; gaps before it per the current idle mix
    task automatic send_req(input req_t r, input logic chk, input rsp_t typed);
        rsp_t predicted;
        begin
            if ($urandom_range(0, 99) < send_idle_pct)
            begin
                req_ch.valid <= 1'b0;
                @(negedge clk);
                while ($urandom_range(0, 99) < send_idle_pct)
                    @(negedge clk);
            end
            req_ch.valid <= 1'b1;
            req_ch.data <= r;
            @(posedge clk);
            while (!req_ch.ready)
                @(posedge clk);
            predicted = alu_predict(r);
            // a typed-in row must agree with the predictor too
            if (chk && predicted != typed)
            begin
                $error("typed result disagrees with predictor: %h vs %h", typed, predicted);
                fail_count++;
            end
            pending_results.push_back(chk ? typed : predicted);
            @(negedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls, optional long hold-off
    // ------------------------------------------------------------------
    always @(negedge clk)
        rsp_ch.ready <= rst_n && !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %h actual %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                fail_count++;
            end
            else
            begin
                rsp_t exp_r;
                exp_r = pending_results.pop_front();
                check_field("result_is_vec", 32'(exp_r.is_vec), 32'(rsp_ch.data.is_vec));
                check_field("result_num", exp_r.num, rsp_ch.data.num);
                check_field("result_x", exp_r.x, rsp_ch.data.x);
                check_field("result_y", exp_r.y, rsp_ch.data.y);
                check_field("result_z", exp_r.z, rsp_ch.data.z);
                check_field("error_code", 32'(exp_r.error_code),
                            32'(rsp_ch.data.error_code));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        localparam logic [31:0] QMAX = 32'h7fff_ffff;
        localparam logic [31:0] QMIN = 32'h8000_0000;
        localparam logic [31:0] ONE = 32'h0001_0000;
        int phase_len[4];
        int n_sent;
        int waited;

        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;

        // directed table: extremes, every op, every type pairing, errors
        add_row(mk_req(CMD_ADD, 1'b0, QMAX, 0, 1'b0, ONE, 0), 1'b1, num_rsp(QMAX));
        add_row(mk_req(CMD_SUB, 1'b0, QMIN, 0, 1'b0, ONE, 0), 1'b1, num_rsp(QMIN));
        add_row(mk_req(CMD_ADD, 1'b0, QMIN, 0, 1'b0, QMIN, 0), 1'b1, num_rsp(QMIN));
        add_row(mk_req(CMD_SUB, 1'b0, QMAX, 0, 1'b0, QMIN, 0), 1'b1, num_rsp(QMAX));
        add_row(mk_req(CMD_ADD, 1'b1, 0, QMAX, 1'b1, 0, ONE), 1'b0, '0);
        add_row(mk_req(CMD_SUB, 1'b1, 0, QMIN, 1'b1, 0, QMAX), 1'b0, '0);
        add_row(mk_req(CMD_ADD, 1'b1, 5, 7, 1'b0, 9, 3), 1'b1, err_rsp(ERR_TYPE));
        add_row(mk_req(CMD_SUB, 1'b0, 5, 7, 1'b1, 9, 3), 1'b1, err_rsp(ERR_TYPE));
        add_row(mk_req(CMD_MUL, 1'b0, QMAX, 0, 1'b0, QMAX, 0), 1'b1, num_rsp(QMAX));
        add_row(mk_req(CMD_MUL, 1'b0, QMIN, 0, 1'b0, QMIN, 0), 1'b1, num_rsp(QMAX));
        add_row(mk_req(CMD_MUL, 1'b0, QMIN, 0, 1'b0, QMAX, 0), 1'b1, num_rsp(QMIN));
        add_row(mk_req(CMD_MUL, 1'b0, 32'hffff_ffff, 0, 1'b0, 1, 0),
                1'b1, num_rsp(32'hffff_ffff));
        add_row(mk_req(CMD_MUL, 1'b0, ONE, 0, 1'b0, 32'h1234_5678, 0),
                1'b1, num_rsp(32'h1234_5678));
        add_row(mk_req(CMD_MUL, 1'b1, 0, QMIN, 1'b0, 32'hfffe_0000, 0), 1'b0, '0);
        add_row(mk_req(CMD_MUL, 1'b0, 32'h0003_8000, 0, 1'b1, 0, 32'hdead_beef), 1'b0, '0);
        add_row(mk_req(CMD_MUL, 1'b1, 0, 32'h0002_0000, 1'b1, 0, QMIN), 1'b0, '0);
        add_row(mk_req(CMD_DIV, 1'b0, ONE, 0, 1'b0, 32'h0003_0000, 0),
                1'b1, num_rsp(32'h0000_5555));
        add_row(mk_req(CMD_DIV, 1'b0, 32'hffff_0000, 0, 1'b0, 32'h0003_0000, 0),
                1'b1, num_rsp(32'hffff_aaab));
        add_row(mk_req(CMD_DIV, 1'b0, QMIN, 0, 1'b0, 1, 0), 1'b1, num_rsp(QMIN));
        add_row(mk_req(CMD_DIV, 1'b0, QMAX, 0, 1'b0, 32'hffff_ffff, 0), 1'b1, num_rsp(QMIN));
        add_row(mk_req(CMD_DIV, 1'b0, QMIN, 0, 1'b0, QMIN, 0), 1'b1, num_rsp(ONE));
        add_row(mk_req(CMD_DIV, 1'b1, 0, QMAX, 1'b0, 32'hfff0_0000, 0), 1'b0, '0);
        add_row(mk_req(CMD_DIV, 1'b0, ONE, 0, 1'b0, 0, 0), 1'b1, err_rsp(ERR_DIV0));
        add_row(mk_req(CMD_DIV, 1'b1, ONE, 7, 1'b1, 0, 0), 1'b1, err_rsp(ERR_TYPE));
        add_row(mk_req(CMD_DIV, 1'b0, ONE, 7, 1'b1, ONE, 3), 1'b1, err_rsp(ERR_TYPE));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[k])
            send_req(directed_rows[k].req, directed_rows[k].chk, directed_rows[k].rsp);

        // random part in four idling mixes
        phase_len = '{N_RANDOM / 4, N_RANDOM / 4, N_RANDOM / 4, N_RANDOM / 4};
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 85 : 37) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 85 : 37) : 0;
            if (ph == 0)
            begin
                // long receiver hold-off so the pipeline fills and backs up
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (120) @(negedge clk);
                        hold_off <= 1'b0;
                    end
                join_none
            end
            n_sent = 0;
            while (n_sent < phase_len[ph])
            begin
                send_req(rand_req(), 1'b0, '0);
                n_sent++;
            end
        end
        req_ch.valid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;

        waited = 0;
        while (pending_results.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge clk);

        if (fail_count == 0 && pending_results.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

### sim.f
src/v3alu_pkg.sv
src/v3alu_if.sv
src/v3alu_front.sv
src/v3alu_back.sv
src/vec3_scalar_alu_top.sv
verif/tb.sv
